// File: rtl/stitch_pattern_raster_generator_assert.svh
// Assertion macros for the stitch pattern raster generator.
// All checks sample on clk and are disabled while arst_n is low.
`ifndef STITCH_PATTERN_RASTER_GENERATOR_ASSERT_SVH
`define STITCH_PATTERN_RASTER_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define SPRG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stitch raster generator: same-cycle check failed");

// Next-cycle implication
`define SPRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stitch raster generator: next-cycle check failed");

`endif

// File: rtl/stpg_pkg.sv
package stpg_pkg;

	// field and register widths
	localparam int GAP_W     = 8;
	localparam int CNT_W     = 7;
	localparam int PIX_W     = 14;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	// default grid capacity
	localparam int MAX_CELLS_DEF = 64;

	// register reset values
	localparam logic [GAP_W-1:0] CELL_GAP_RST   = 8'd16;
	localparam logic [GAP_W-1:0] LINE_WIDTH_RST = 8'd1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CELL_GAP     = 3'd0,
		CFG_LINE_WIDTH   = 3'd1,
		CFG_COLUMN_COUNT = 3'd2,
		CFG_ROW_COUNT    = 3'd3,
		CFG_COLUMN_BITS  = 3'd4,
		CFG_ROW_BITS     = 3'd5
	} cfg_reg_t;

endpackage

// File: rtl/stitch_pattern_raster_generator.sv
// Stitch pattern raster generator: each accepted word on the input channel
// produces the next pixel of the frame in raster order (or pixel (0,0) of a
// new frame when restart is set), with its coordinates, its ink bit and
// end-of-line / end-of-frame marks. One pixel per clock is sustained while
// out_ready holds: the position counters update in the cycle a word is
// accepted and the pixel is held in a single output register, so a new
// word is taken whenever that register is empty or drains in the same cycle;
// the pixel shows in the cycle after its word. A zero cell_gap, column_count
// or row_count gives an empty frame (word consumed, no pixel). The user
// must write config via the plain write port only while idle (not enforced).
module stitch_pattern_raster_generator
	import stpg_pkg::*;
#(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     pixel_x,
	output logic [PIX_W-1:0]     pixel_y,
	output logic                 ink,
	output logic                 end_of_line,
	output logic                 end_of_frame
);

	localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	// configuration registers
	logic [GAP_W-1:0]     cell_gap_q;
	logic [GAP_W-1:0]     line_width_q;
	logic [CNT_W-1:0]     column_count_q;
	logic [CNT_W-1:0]     row_count_q;
	logic [MAX_CELLS-1:0] column_bits_q;
	logic [MAX_CELLS-1:0] row_bits_q;

	// position of the next pixel
	logic [CELL_W-1:0] cur_col_q;
	logic [GAP_W-1:0]  cur_xo_q;
	logic [CELL_W-1:0] cur_row_q;
	logic [GAP_W-1:0]  cur_yo_q;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_x_q;
	logic [PIX_W-1:0] pixel_y_q;
	logic             ink_q;
	logic             eol_q;
	logic             eof_q;

	// pixel logic
	logic              in_acc;
	logic [CNT_W-1:0]  cols;
	logic [CNT_W-1:0]  rows;
	logic [GAP_W-1:0]  thick;
	logic              empty;
	logic              go_home;
	logic [CELL_W-1:0] c;
	logic [CELL_W-1:0] r;
	logic [GAP_W-1:0]  xo;
	logic [GAP_W-1:0]  yo;
	logic              last_x;
	logic              last_y;
	logic              eol;
	logic              eof;
	logic              ink_d;
	logic [PIX_W-1:0]  pix_x_d;
	logic [PIX_W-1:0]  pix_y_d;
	logic [CELL_W-1:0] nxt_col;
	logic [GAP_W-1:0]  nxt_xo;
	logic [CELL_W-1:0] nxt_row;
	logic [GAP_W-1:0]  nxt_yo;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_gap_q     <= CELL_GAP_RST;
			line_width_q   <= LINE_WIDTH_RST;
			column_count_q <= '0;
			row_count_q    <= '0;
			column_bits_q  <= '0;
			row_bits_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_CELL_GAP:     cell_gap_q     <= cfg_wdata[GAP_W-1:0];
				CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata[GAP_W-1:0];
				CFG_COLUMN_COUNT: column_count_q <= cfg_wdata[CNT_W-1:0];
				CFG_ROW_COUNT:    row_count_q    <= cfg_wdata[CNT_W-1:0];
				CFG_COLUMN_BITS:  column_bits_q  <= cfg_wdata[MAX_CELLS-1:0];
				CFG_ROW_BITS:     row_bits_q     <= cfg_wdata[MAX_CELLS-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size and stroke thickness
	assign cols  = (column_count_q > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : column_count_q;
	assign rows  = (row_count_q > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : row_count_q;
	assign thick = (line_width_q < cell_gap_q) ? line_width_q : cell_gap_q;
	assign empty = (cell_gap_q == '0) || (cols == '0) || (rows == '0);

	// restart, or a stale position after a register change, starts at (0,0)
	assign go_home = restart || (CNT_W'(cur_col_q) >= cols) || (CNT_W'(cur_row_q) >= rows)
		|| (cur_xo_q >= cell_gap_q) || (cur_yo_q >= cell_gap_q);

	assign c  = go_home ? '0 : cur_col_q;
	assign r  = go_home ? '0 : cur_row_q;
	assign xo = go_home ? '0 : cur_xo_q;
	assign yo = go_home ? '0 : cur_yo_q;

	// pixel attributes
	assign last_x = (xo == cell_gap_q - GAP_W'(1));
	assign last_y = (yo == cell_gap_q - GAP_W'(1));
	assign eol    = last_x && (CNT_W'(c) == cols - CNT_W'(1));
	assign eof    = eol && last_y && (CNT_W'(r) == rows - CNT_W'(1));

	assign ink_d = ((yo < thick) && (c[0] == row_bits_q[r]))
		|| ((xo < thick) && (r[0] == column_bits_q[c]))
		|| ((c != '0) && (r != '0) && (xo < thick) && (yo < thick));

	assign pix_x_d = PIX_W'(c) * PIX_W'(cell_gap_q) + PIX_W'(xo);
	assign pix_y_d = PIX_W'(r) * PIX_W'(cell_gap_q) + PIX_W'(yo);

	// advance the raster position
	always_comb begin
		nxt_col = c;
		nxt_xo  = xo;
		nxt_row = r;
		nxt_yo  = yo;
		if (empty || eof) begin
			nxt_col = '0;
			nxt_xo  = '0;
			nxt_row = '0;
			nxt_yo  = '0;
		end else if (eol) begin
			nxt_col = '0;
			nxt_xo  = '0;
			if (!last_y) begin
				nxt_yo = yo + GAP_W'(1);
			end else begin
				nxt_yo  = '0;
				nxt_row = r + CELL_W'(1);
			end
		end else if (!last_x) begin
			nxt_xo = xo + GAP_W'(1);
		end else begin
			nxt_xo  = '0;
			nxt_col = c + CELL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_xo_q  <= '0;
			cur_row_q <= '0;
			cur_yo_q  <= '0;
		end else if (in_acc) begin
			cur_col_q <= nxt_col;
			cur_xo_q  <= nxt_xo;
			cur_row_q <= nxt_row;
			cur_yo_q  <= nxt_yo;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= !empty;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (in_acc && !empty) begin
			pixel_x_q <= pix_x_d;
			pixel_y_q <= pix_y_d;
			ink_q     <= ink_d;
			eol_q     <= eol;
			eof_q     <= eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign ink          = ink_q;
	assign end_of_line  = eol_q;
	assign end_of_frame = eof_q;

	// checks
	`include "stitch_pattern_raster_generator_assert.svh"

	`SPRG_ASSERT_NOW(a_eof_has_eol, out_valid_q, !eof_q || eol_q)
	`SPRG_ASSERT_NEXT(a_empty_no_word, in_acc && empty, !out_valid_q)
	`SPRG_ASSERT_NEXT(a_word_follows, in_acc && !empty, out_valid_q)
	`SPRG_ASSERT_NEXT(a_restart_origin, in_acc && !empty && restart,
		(pixel_x_q == '0) && (pixel_y_q == '0))

endmodule

// File: dv/tb_stitch_pattern_raster_generator.sv
`timescale 1ns / 100ps

module tb_stitch_pattern_raster_generator
	import stpg_pkg::*;
();

	// indexes past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic             ink;
		logic             eol;
		logic             eof;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 restart = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_W-1:0]     pixel_x;
	logic [PIX_W-1:0]     pixel_y;
	logic                 ink;
	logic                 end_of_line;
	logic                 end_of_frame;

	// register copies, reset values
	logic [GAP_W-1:0] grid_gap = CELL_GAP_RST;
	logic [GAP_W-1:0] grid_width = LINE_WIDTH_RST;
	logic [CNT_W-1:0] grid_cols = '0;
	logic [CNT_W-1:0] grid_rows = '0;
	logic [63:0]      grid_col_bits = '0;
	logic [63:0]      grid_row_bits = '0;

	// raster position of the next pixel
	logic [5:0] at_col = '0;
	logic [7:0] at_xo = '0;
	logic [5:0] at_row = '0;
	logic [7:0] at_yo = '0;

	bit     restart_words[$];
	pixel_t pixels_expected[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int pixels_checked = 0;
	int line_ends = 0;
	int frame_ends = 0;
	int settings_tried = 0;
	int phase_no = 0;

	stitch_pattern_raster_generator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.ink          (ink),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop
	initial begin
		#400000;
		$display("** stitch_pattern_raster_generator: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void go_home();
		at_col = '0;
		at_xo = '0;
		at_row = '0;
		at_yo = '0;
	endfunction

	// next pixel of the raster for one accepted word
	function automatic void predict_pixel(input logic new_frame);
		int cols, rows, gap, thick, c, r, xo, yo;
		logic ink_bit, eol_bit, eof_bit;
		pixel_t px;
		cols = (grid_cols > MAX_CELLS_DEF) ? MAX_CELLS_DEF : int'(grid_cols);
		rows = (grid_rows > MAX_CELLS_DEF) ? MAX_CELLS_DEF : int'(grid_rows);
		gap = grid_gap;
		thick = (grid_width < grid_gap) ? int'(grid_width) : gap;
		// empty frame: word consumed, nothing out
		if (gap == 0 || cols == 0 || rows == 0) begin
			go_home();
			return;
		end
		// restart, or a position left stale by a register change
		if (new_frame || at_col >= cols || at_row >= rows || at_xo >= gap || at_yo >= gap)
			go_home();
		c = at_col;
		r = at_row;
		xo = at_xo;
		yo = at_yo;
		ink_bit = (yo < thick && (c % 2) == grid_row_bits[r]) ||
			(xo < thick && (r % 2) == grid_col_bits[c]) ||
			(c >= 1 && r >= 1 && xo < thick && yo < thick);
		eol_bit = (xo == gap - 1) && (c == cols - 1);
		eof_bit = eol_bit && (yo == gap - 1) && (r == rows - 1);
		px.x = PIX_W'(c * gap + xo);
		px.y = PIX_W'(r * gap + yo);
		px.ink = ink_bit;
		px.eol = eol_bit;
		px.eof = eof_bit;
		pixels_expected.push_back(px);
		// advance in raster order
		if (eof_bit) begin
			go_home();
		end else if (eol_bit) begin
			at_col = '0;
			at_xo = '0;
			if (yo + 1 < gap) begin
				at_yo = 8'(yo + 1);
			end else begin
				at_yo = '0;
				at_row = 6'(r + 1);
			end
		end else if (xo + 1 < gap) begin
			at_xo = 8'(xo + 1);
		end else begin
			at_xo = '0;
			at_col = 6'(c + 1);
		end
	endfunction

	// driver: predicts on accept, then presents the next word or idles
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_pixel(restart);
			if (!in_valid || in_ready) begin
				if (restart_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					restart <= restart_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted pixel against the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixels_expected.size() == 0) begin
					report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
						pixel_x, pixel_y));
				end else begin
					want = pixels_expected.pop_front();
					pixels_checked++;
					if (end_of_line)
						line_ends++;
					if (end_of_frame)
						frame_ends++;
					if (pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, want.x));
					if (pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, want.y));
					if (ink !== want.ink)
						report_mismatch($sformatf("ink %b at (%0d,%0d), want %b",
							ink, want.x, want.y, want.ink));
					if (end_of_line !== want.eol)
						report_mismatch($sformatf("end_of_line %b at (%0d,%0d), want %b",
							end_of_line, want.x, want.y, want.eol));
					if (end_of_frame !== want.eof)
						report_mismatch($sformatf("end_of_frame %b at (%0d,%0d), want %b",
							end_of_frame, want.x, want.y, want.eof));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// all words taken and all pixels out, plus room for a word that gives none
	task automatic wait_idle();
		do
			@(posedge clk);
		while (restart_words.size() != 0 || in_valid || pixels_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_CELL_GAP:     grid_gap = val[GAP_W-1:0];
			CFG_LINE_WIDTH:   grid_width = val[GAP_W-1:0];
			CFG_COLUMN_COUNT: grid_cols = val[CNT_W-1:0];
			CFG_ROW_COUNT:    grid_rows = val[CNT_W-1:0];
			CFG_COLUMN_BITS:  grid_col_bits = val;
			CFG_ROW_BITS:     grid_row_bits = val;
			default: ;
		endcase
	endtask

	task automatic program_grid(input int gap, input int width, input int cols, input int rows,
		input logic [63:0] col_bits, input logic [63:0] row_bits);
		write_reg(CFG_CELL_GAP, CFG_W'(gap));
		write_reg(CFG_LINE_WIDTH, CFG_W'(width));
		write_reg(CFG_COLUMN_COUNT, CFG_W'(cols));
		write_reg(CFG_ROW_COUNT, CFG_W'(rows));
		write_reg(CFG_COLUMN_BITS, col_bits);
		write_reg(CFG_ROW_BITS, row_bits);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_tried++;
	endtask

	// random words in two halves with a full drain between them
	task automatic run_phase(input int count, input int restart_pct);
		case (phase_no % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
			default: begin send_idle_pct = 24; recv_stall_pct = 24; end
		endcase
		phase_no++;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_idle();
			restart_words.push_back($urandom_range(99) < restart_pct);
		end
		wait_idle();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: zero counts, empty frame
		restart_words.push_back(1'b0);
		restart_words.push_back(1'b1);
		wait_idle();

		// 2x2 grid of 2-pixel cells: one full frame, wrap, then restart mid-frame
		program_grid(2, 1, 2, 2, 64'h2, 64'h1);
		write_reg(CFG_SPARE_LO, rand64());
		write_reg(CFG_SPARE_HI, '1);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		restart_words.push_back(1'b1);
		repeat (17) restart_words.push_back(1'b0);
		restart_words.push_back(1'b1);
		wait_idle();

		// widest cell, full stroke, all phase bits set
		program_grid(255, 255, 1, 1, '1, '1);
		restart_words.push_back(1'b1);
		repeat (2) restart_words.push_back(1'b0);
		wait_idle();

		// random part across settings and idle mixes
		program_grid(3, 1, 4, 3, rand64(), rand64());
		run_phase(120, 3);
		program_grid(1, 1, 64, 2, rand64(), rand64());
		run_phase(140, 3);
		program_grid(2, 0, 127, 1, rand64(), rand64());
		run_phase(260, 0);
		program_grid(255, 255, 1, 127, rand64(), rand64());
		run_phase(100, 30);
		program_grid(5, 255, 3, 2, rand64(), rand64());
		run_phase(160, 3);
		program_grid(0, 3, 4, 4, rand64(), rand64());
		run_phase(6, 3);
		program_grid(7, 3, 64, 0, rand64(), rand64());
		run_phase(6, 3);
		// leave the position deep in a large grid, then shrink it under it
		program_grid(4, 2, 64, 64, rand64(), rand64());
		run_phase(80, 0);
		program_grid(3, 2, 2, 2, rand64(), rand64());
		run_phase(80, 3);
		repeat (3) begin
			program_grid($urandom_range(1, 6), $urandom_range(0, 7), $urandom_range(1, 8),
				$urandom_range(1, 5), rand64(), rand64());
			run_phase(50, 5);
		end

		repeat (10) @(posedge clk);
		if (pixels_expected.size() != 0)
			report_mismatch($sformatf("%0d pixels never came out", pixels_expected.size()));

		$display("Checked %0d pixels over %0d grid settings and %0d idle phases,",
			pixels_checked, settings_tried, phase_no);
		$display("seeing %0d line ends and %0d frame ends; %0d mismatches.",
			line_ends, frame_ends, mismatch_count);
		if (mismatch_count == 0) begin
			$display("** stitch_pattern_raster_generator: PASSED **");
		end else begin
			$display("** stitch_pattern_raster_generator: FAILED **");
		end
		$finish;
	end

endmodule
